FILE: hdl/thb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_pkg: shared definitions of the task heartbeat supervisor
// Sizes, command codes, register indexes and the structs passed between
// the supervisor's modules.
// ----------------------------------------------------------------------------
package thb_pkg;

	// Number of supervised clients and the width of a client slot index.
	localparam int NUM_TASKS  = 8;
	localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// Widths of the item fields.
	localparam int CMD_W      = 2;
	localparam int TASK_W     = 8;
	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;

	// Configuration port sizes.
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	// Command codes carried by an input item.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 2'd0,
		CMD_HEARTBEAT = 2'd1,
		CMD_START     = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_DEADLINE = 2'd0,
		REG_WARMUP   = 2'd1,
		REG_PERIOD   = 2'd2,
		REG_UNUSED   = 2'd3
	} reg_idx_t;

	// Configuration values seen by the sequencer.
	typedef struct packed {
		logic [CFG_W-1:0] deadline;
		logic [CFG_W-1:0] warmup;
		logic [CFG_W-1:0] period;
	} cfg_t;

	// Control from the sequencer to the heartbeat store.
	typedef struct packed {
		logic                  wr_en;
		logic [TASK_IDX_W-1:0] wr_addr;
		logic [TIME_W-1:0]     wr_data;
		logic                  reseed;
		logic                  rd_en;
		logic [TASK_IDX_W-1:0] rd_addr;
	} store_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/thb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_in_if: input item channel
// Valid/ready channel carrying a command and a client index.
// ----------------------------------------------------------------------------
interface thb_in_if;
	logic                      valid;
	logic                      ready;
	logic [thb_pkg::CMD_W-1:0]  cmd;
	logic [thb_pkg::TASK_W-1:0] task_index;

	modport source (output valid, output cmd, output task_index, input ready);
	modport sink   (input valid, input cmd, input task_index, output ready);
endinterface
`default_nettype wire

FILE: hdl/thb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_out_if: result item channel
// Valid/ready channel carrying the supervision status of one item.
// ----------------------------------------------------------------------------
interface thb_out_if;
	logic valid;
	logic ready;
	logic refresh;
	logic missed;
	logic error_flag;
	logic warming_up;

	modport source (output valid, output refresh, output missed, output error_flag,
		output warming_up, input ready);
	modport sink   (input valid, input refresh, input missed, input error_flag,
		input warming_up, output ready);
endinterface
`default_nettype wire

FILE: hdl/thb_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_cfg_regs: configuration registers
// APB-style register file holding deadline, warmup and check period.
// ----------------------------------------------------------------------------
module thb_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [thb_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [thb_pkg::PDATA_W-1:0]  pwdata,
	output logic      [thb_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output thb_pkg::cfg_t                     cfg
);

	logic [thb_pkg::CFG_W-1:0] deadline_q;
	logic [thb_pkg::CFG_W-1:0] warmup_q;
	logic [thb_pkg::CFG_W-1:0] period_q;
	thb_pkg::reg_idx_t         reg_idx;
	logic                      wr_en;

	assign pready  = 1'b1;
	assign reg_idx = thb_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; an address beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= 16'd500;
			warmup_q   <= 16'd2000;
			period_q   <= 16'd100;
		end else if (wr_en) begin
			case (reg_idx)
				thb_pkg::REG_DEADLINE: deadline_q <= pwdata[thb_pkg::CFG_W-1:0];
				thb_pkg::REG_WARMUP:   warmup_q   <= pwdata[thb_pkg::CFG_W-1:0];
				thb_pkg::REG_PERIOD:   period_q   <= pwdata[thb_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back of the selected register.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			thb_pkg::REG_DEADLINE: prdata = thb_pkg::PDATA_W'(deadline_q);
			thb_pkg::REG_WARMUP:   prdata = thb_pkg::PDATA_W'(warmup_q);
			thb_pkg::REG_PERIOD:   prdata = thb_pkg::PDATA_W'(period_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.deadline = deadline_q;
	assign cfg.warmup   = warmup_q;
	assign cfg.period   = period_q;

endmodule
`default_nettype wire

FILE: hdl/thb_beat_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_beat_store: client heartbeat timestamp memory
// Synchronous memory of last-beat times with a registered read port. A slot
// not written since reset or start reads as the common seed time.
// ----------------------------------------------------------------------------
module thb_beat_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire thb_pkg::store_ctl_t         ctl,
	output logic      [thb_pkg::TIME_W-1:0]  beat_s1
);

	logic [thb_pkg::TIME_W-1:0] mem [thb_pkg::NUM_TASKS];
	logic [thb_pkg::NUM_TASKS-1:0] valid_q;
	logic [thb_pkg::TIME_W-1:0] seed_q;
	logic [thb_pkg::TIME_W-1:0] rd_s1;
	logic                       vld_s1;

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_s1 <= mem[ctl.rd_addr];
		end
	end

	// Slot valid bits and the seed time; a start invalidates every slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seed_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (ctl.reseed) begin
				valid_q <= '0;
				seed_q  <= ctl.wr_data;
			end else if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				vld_s1 <= valid_q[ctl.rd_addr];
			end
		end
	end

	assign beat_s1 = vld_s1 ? rd_s1 : seed_q;

endmodule
`default_nettype wire

FILE: hdl/task_heartbeat_supervisor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// task_heartbeat_supervisor: multi-client heartbeat watchdog
// Sequencer that keeps time, stamps heartbeats and walks the timestamp store.
// ----------------------------------------------------------------------------
// Usage:
// Input items on "items" carry a command (tick, heartbeat, start) and a client
// index; each gives exactly one result item on "results" with the refresh and
// missed pulses, the sticky error and the warmup status after that item.
// The APB port sets deadline, warmup and check period; write it while idle.
// Timing: an item that runs no timestamp walk (no check, or a check during
// warmup) goes from acceptance to the hold state and then to the output
// register. A check after warmup reads every client slot through the one read
// port of the timestamp memory, one slot a cycle, then the final compare.
// One item is worked on at a time; the next is taken once the result has
// moved to the output register, even while the receiver has not yet taken it.
// A stalled receiver holds the result in the output register and the block
// stops taking items only once a second result is ready behind it.
// Reset clears time, timestamps, counters, armed and error state at once and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module task_heartbeat_supervisor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	thb_in_if.sink                            items,
	thb_out_if.source                         results,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [thb_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [thb_pkg::PDATA_W-1:0]  pwdata,
	output logic      [thb_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	typedef struct packed {
		logic refresh;
		logic missed;
		logic error_flag;
		logic warming_up;
	} res_t;

	state_t                          state_q;
	thb_pkg::cfg_t                   cfg;
	thb_pkg::store_ctl_t             ctl;
	logic [thb_pkg::TIME_W-1:0]      beat_s1;
	logic [thb_pkg::TIME_W-1:0]      time_q;
	logic [thb_pkg::TIME_W-1:0]      wend_q;
	logic [thb_pkg::CFG_W-1:0]       pcount_q;
	logic                            armed_q;
	logic                            err_q;
	logic                            warm_q;
	logic                            fail_q;
	logic [thb_pkg::TASK_IDX_W-1:0]  idx_q;
	logic                            rd_valid_s1;
	res_t                            res_q;
	res_t                            out_q;
	logic                            out_valid_q;

	logic                            accept;
	thb_pkg::cmd_t                   cmd;
	logic [thb_pkg::TIME_W-1:0]      time_n;
	logic [thb_pkg::TIME_W-1:0]      wend_n;
	logic [thb_pkg::TIME_W-1:0]      wdiff;
	logic [thb_pkg::CFG_W-1:0]       pcount_n;
	logic [thb_pkg::CFG_W-1:0]       pcount_inc;
	logic                            armed_n;
	logic                            checked;
	logic                            warm_n;
	logic [thb_pkg::TIME_W-1:0]      age;
	logic                            late;
	logic                            fail_tot;
	logic                            last_issue;
	logic                            out_load;

	thb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	thb_beat_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.beat_s1 (beat_s1)
	);

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign cmd         = thb_pkg::cmd_t'(items.cmd);

	// Next time-keeping state for the item being accepted.
	always_comb begin
		time_n     = time_q;
		wend_n     = wend_q;
		pcount_n   = pcount_q;
		armed_n    = armed_q;
		checked    = 1'b0;
		pcount_inc = pcount_q + 16'd1;
		case (cmd)
			thb_pkg::CMD_TICK: begin
				time_n = time_q + 32'd1;
				if (armed_q) begin
					if (pcount_inc >= cfg.period) begin
						pcount_n = '0;
						checked  = 1'b1;
					end else begin
						pcount_n = pcount_inc;
					end
				end
			end
			thb_pkg::CMD_START: begin
				wend_n   = time_q + thb_pkg::TIME_W'(cfg.warmup);
				armed_n  = 1'b1;
				pcount_n = '0;
				checked  = 1'b1;
			end
			default: ;
		endcase
		wdiff  = time_n - wend_n;
		warm_n = armed_n && wdiff[thb_pkg::TIME_W-1];
	end

	// Store control: heartbeat writes, start reseeds, the walk reads.
	always_comb begin
		ctl.wr_en   = 1'b0;
		ctl.wr_addr = items.task_index[thb_pkg::TASK_IDX_W-1:0];
		ctl.wr_data = time_q;
		ctl.reseed  = 1'b0;
		ctl.rd_en   = (state_q == ST_WALK);
		ctl.rd_addr = idx_q;
		if (accept && (cmd == thb_pkg::CMD_HEARTBEAT)
			&& (items.task_index < thb_pkg::TASK_W'(thb_pkg::NUM_TASKS))) begin
			ctl.wr_en = 1'b1;
		end
		if (accept && (cmd == thb_pkg::CMD_START)) begin
			ctl.reseed = 1'b1;
		end
	end

	// Age test on the slot read in the previous cycle.
	assign age        = time_q - beat_s1;
	assign late       = rd_valid_s1 && (age > thb_pkg::TIME_W'(cfg.deadline));
	assign fail_tot   = fail_q || late;
	assign last_issue = (idx_q == thb_pkg::TASK_IDX_W'(thb_pkg::NUM_TASKS - 1));
	assign out_load   = (state_q == ST_HOLD) && (!out_valid_q || results.ready);

	// Sequencer and supervision state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			wend_q      <= '0;
			pcount_q    <= '0;
			armed_q     <= 1'b0;
			err_q       <= 1'b0;
			warm_q      <= 1'b0;
			fail_q      <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ctl.rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						time_q   <= time_n;
						wend_q   <= wend_n;
						pcount_q <= pcount_n;
						armed_q  <= armed_n;
						warm_q   <= warm_n;
						fail_q   <= 1'b0;
						idx_q    <= '0;
						state_q  <= (checked && !warm_n) ? ST_WALK : ST_HOLD;
					end
				end
				ST_WALK: begin
					fail_q <= fail_tot;
					idx_q  <= idx_q + 1'b1;
					if (last_issue) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					err_q   <= err_q || fail_tot;
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result staging for the item in work.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.refresh    <= checked;
			res_q.missed     <= 1'b0;
			res_q.error_flag <= err_q;
			res_q.warming_up <= warm_n;
		end else if (state_q == ST_FIN) begin
			res_q.refresh    <= !fail_tot;
			res_q.missed     <= fail_tot;
			res_q.error_flag <= err_q || fail_tot;
			res_q.warming_up <= warm_q;
		end
	end

	// Output register towards the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.refresh    = out_q.refresh;
	assign results.missed     = out_q.missed;
	assign results.error_flag = out_q.error_flag;
	assign results.warming_up = out_q.warming_up;

`ifndef SYNTHESIS
	// The sticky error only ever rises until the next reset.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("sticky error cleared");

	// A missed check is always reported together with the error flag.
	a_missed_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.missed) |-> (out_q.error_flag && !out_q.refresh))
		else $error("missed result without error flag");

	// A timestamp walk only runs while supervision is armed and past warmup.
	a_walk_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (armed_q && !warm_q))
		else $error("walk while unarmed or warming up");

	// The final compare always sees a slot read from the last walk cycle.
	a_fin_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> rd_valid_s1)
		else $error("walk finished without a pending read");
`endif

endmodule
`default_nettype wire
